// ===== rtl/frxcrc_pkg.sv =====
// shared types and constants of the framed byte receiver with crc-16 check
package frxcrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int OPCODE_W  = 5;
    localparam int LENGTH_W  = 11;
    localparam int CRC_W     = 16;
    localparam int LIMIT_W   = 6;
    localparam int TOTAL_W   = 16;

    localparam logic [BYTE_W-1:0]   START_BYTE  = 8'h02;
    localparam logic [BYTE_W-1:0]   END_BYTE    = 8'h03;
    localparam logic [CRC_W-1:0]    CRC_POLY    = 16'h1021;
    localparam logic [CRC_W-1:0]    CRC_INIT    = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 6'd32;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_READY   = 3'd0,
        PH_HEAD_HI = 3'd1,
        PH_HEAD_LO = 3'd2,
        PH_DATA    = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_TAIL    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        K_PAYLOAD    = 3'd0,
        K_OK         = 3'd1,
        K_BAD_START  = 3'd2,
        K_BAD_OPCODE = 3'd3,
        K_BAD_CRC    = 3'd4,
        K_BAD_END    = 3'd5
    } kind_t;

    typedef struct packed {
        logic                 have;
        kind_t                kind;
        logic [BYTE_W-1:0]    payload_byte;
        logic [OPCODE_W-1:0]  frame_opcode;
        logic [LENGTH_W-1:0]  frame_length;
        logic [TOTAL_W-1:0]   error_total;
    } rx_result_t;

endpackage

// ===== rtl/frame_receiver_crc16.sv =====
// top level: input register, frame logic and result register of the frame receiver
// an accepted byte is held in the input register, then its result in the result register, which drives m_tvalid
// throughput: one byte per cycle, sustained while the result side takes a request each cycle
// the input register refills in the same cycle that its byte moves into the frame logic
// reset: rst_n asynchronous, active low; clears both registers' valid flags, the frame
// state, the crc (to 0xffff), the error counter and sets the opcode limit to 32
module frame_receiver_crc16 #(
    parameter int ERROR_COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // frame results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [12:8] frame_opcode,
                                   // [23:13] frame_length, [39:24] error_total
    output logic [2:0]  m_tuser,   // [2:0] kind
    // opcode limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // [5:0] opcode_limit
);
    import frxcrc_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic              out_valid_reg;
    rx_result_t        out_reg;

    logic [LIMIT_W-1:0] opcode_limit_reg;

    rx_result_t        res;
    logic              advance;

    // the held byte moves on when the result register is empty or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    frxcrc_core #(
        .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .rx_byte      (in_byte_reg),
        .opcode_limit (opcode_limit_reg),
        .result       (res)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // result stage: bytes with no result leave it untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.have)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.have)
        begin
            out_reg <= res;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            opcode_limit_reg <= cfg_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.error_total, out_reg.frame_length,
                       out_reg.frame_opcode, out_reg.payload_byte};

`ifndef SYNTHESIS
    // every error kind comes with a non-zero error total
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_BAD_START || m_tuser == K_BAD_OPCODE ||
                     m_tuser == K_BAD_CRC || m_tuser == K_BAD_END)
        |-> m_tdata[39:24] != '0)
        else $error("error request with zero error total");

    // only payload requests carry a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != K_PAYLOAD |-> m_tdata[7:0] == '0)
        else $error("non-payload request carries a byte");

    // the error total never goes down
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.have |-> res.error_total >= $past(res.error_total) ||
                                !$past(advance && res.have))
        else $error("error total decreased");
`endif

endmodule

// ===== rtl/frxcrc_crc_byte.sv =====
// crc-16 (poly 0x1021, msb first) update by one byte, unrolled over eight bits
module frxcrc_crc_byte (
    input  logic [frxcrc_pkg::CRC_W-1:0]  crc_in,
    input  logic [frxcrc_pkg::BYTE_W-1:0] data_in,
    output logic [frxcrc_pkg::CRC_W-1:0]  crc_out
);
    import frxcrc_pkg::*;

    always_comb
    begin
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ data_in[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/frxcrc_core.sv =====
// frame state machine, header and crc registers, error counter
module frxcrc_core #(
    parameter int ERROR_COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [frxcrc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [frxcrc_pkg::LIMIT_W-1:0] opcode_limit,
    output frxcrc_pkg::rx_result_t         result
);
    import frxcrc_pkg::*;

    localparam logic [ERROR_COUNT_BITS-1:0] CNT_SAT = ERROR_COUNT_BITS'(TOTAL_MAX);

    phase_t                      phase_reg, phase_next;
    logic [BYTE_W-1:0]           header_high_reg, header_high_next;
    logic [OPCODE_W-1:0]         opcode_reg, opcode_next;
    logic [LENGTH_W-1:0]         length_reg, length_next;
    logic [LENGTH_W-1:0]         count_reg, count_next;
    logic [CRC_W-1:0]            crc_reg, crc_next;
    logic [ERROR_COUNT_BITS-1:0] err_cnt_reg, err_cnt_next;

    logic [CRC_W-1:0]            crc_upd;
    logic [LENGTH_W-1:0]         count_inc;
    logic                        opcode_bad;
    logic [LENGTH_W-1:0]         head_length;
    logic                        err_inc;

    frxcrc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign count_inc   = count_reg + LENGTH_W'(1);
    assign opcode_bad  = {1'b0, rx_byte[BYTE_W-1:3]} >= opcode_limit;
    assign head_length = {header_high_reg[2:0], rx_byte};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEAD_HI: phase_next = opcode_bad ? PH_READY : PH_HEAD_LO;
            PH_HEAD_LO: phase_next = (head_length == '0) ? PH_CRC_HI : PH_DATA;
            PH_DATA:    phase_next = (count_inc >= length_reg) ? PH_CRC_HI : PH_DATA;
            PH_CRC_HI:  phase_next = PH_CRC_LO;
            PH_CRC_LO:  phase_next = (crc_upd != '0) ? PH_READY : PH_TAIL;
            PH_TAIL:    phase_next = PH_READY;
            default:    phase_next = (rx_byte == START_BYTE) ? PH_HEAD_HI : PH_READY;
        endcase
    end

    // datapath and result
    always_comb
    begin
        header_high_next    = header_high_reg;
        opcode_next         = opcode_reg;
        length_next         = length_reg;
        count_next          = count_reg;
        crc_next            = crc_reg;
        err_inc             = 1'b0;
        result.have         = 1'b0;
        result.kind         = K_PAYLOAD;
        result.payload_byte = '0;
        unique case (phase_reg)
            PH_HEAD_HI:
            begin
                if (opcode_bad)
                begin
                    err_inc     = 1'b1;
                    result.have = 1'b1;
                    result.kind = K_BAD_OPCODE;
                end
                else
                begin
                    header_high_next = rx_byte;
                end
            end
            PH_HEAD_LO:
            begin
                opcode_next = header_high_reg[BYTE_W-1:3];
                length_next = head_length;
                count_next  = '0;
                crc_next    = CRC_INIT;
            end
            PH_DATA:
            begin
                crc_next            = crc_upd;
                count_next          = count_inc;
                result.have         = 1'b1;
                result.kind         = K_PAYLOAD;
                result.payload_byte = rx_byte;
            end
            PH_CRC_HI:
            begin
                crc_next = crc_upd;
            end
            PH_CRC_LO:
            begin
                crc_next = crc_upd;
                if (crc_upd != '0)
                begin
                    err_inc     = 1'b1;
                    result.have = 1'b1;
                    result.kind = K_BAD_CRC;
                end
            end
            PH_TAIL:
            begin
                result.have = 1'b1;
                if (rx_byte != END_BYTE)
                begin
                    err_inc     = 1'b1;
                    result.kind = K_BAD_END;
                end
                else
                begin
                    result.kind = K_OK;
                end
            end
            default:
            begin
                if (rx_byte != START_BYTE)
                begin
                    err_inc     = 1'b1;
                    result.have = 1'b1;
                    result.kind = K_BAD_START;
                end
            end
        endcase

        err_cnt_next = (err_inc && (err_cnt_reg != '1))
                     ? err_cnt_reg + ERROR_COUNT_BITS'(1) : err_cnt_reg;

        result.frame_opcode = opcode_next;
        result.frame_length = length_next;
        // shown saturated at the width of the output field
        result.error_total  = (err_cnt_next > CNT_SAT) ? TOTAL_MAX : TOTAL_W'(err_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_READY;
            header_high_reg <= '0;
            opcode_reg      <= '0;
            length_reg      <= '0;
            count_reg       <= '0;
            crc_reg         <= CRC_INIT;
            err_cnt_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            header_high_reg <= header_high_next;
            opcode_reg      <= opcode_next;
            length_reg      <= length_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            err_cnt_reg     <= err_cnt_next;
        end
    end

endmodule
